FILE: src/lpc_pkg.sv
package lpc_pkg;

    // mode register codes
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_AUTO = 2'd2;

    // mode machine state codes
    localparam logic [2:0] ST_INIT     = 3'd0;
    localparam logic [2:0] ST_MAN_ON   = 3'd1;
    localparam logic [2:0] ST_MAN_OFF  = 3'd2;
    localparam logic [2:0] ST_READY    = 3'd3;
    localparam logic [2:0] ST_HOLD     = 3'd4;
    localparam logic [2:0] ST_HOLD_CLR = 3'd5;

    // configuration register indexes
    localparam logic REG_MODE      = 1'b0;
    localparam logic REG_HOLD_TIME = 1'b1;

    localparam logic [1:0]  MODE_RESET      = MODE_OFF;
    localparam logic [15:0] HOLD_TIME_RESET = 16'd1000;

    // setting units to ticks: times 100, divided by 128
    localparam int          HoldShift = 7;
    localparam logic [22:0] HOLD_MUL  = 23'd100;

    typedef struct packed {
        logic        out_disable;
        logic        dut_active;
        logic        led_on;
        logic        oc_clear;
        logic        sel_alert;
        logic [15:0] event_count;
        logic [2:0]  mode_state;
    } t_result;

    function automatic logic [15:0] hold_ticks(input logic [15:0] hold_time);
        logic [22:0] prod;
        prod = {7'd0, hold_time} * HOLD_MUL;
        return prod[22:HoldShift];
    endfunction

endpackage

FILE: src/lpc_in_if.sv
interface lpc_in_if;
    logic valid;
    logic ready;
    logic sel_event;
    logic clear_count;

    modport source (output valid, output sel_event, output clear_count, input ready);
    modport sink (input valid, input sel_event, input clear_count, output ready);
endinterface

FILE: src/lpc_out_if.sv
interface lpc_out_if;
    logic        valid;
    logic        ready;
    logic        out_disable;
    logic        dut_active;
    logic        led_on;
    logic        oc_clear;
    logic        sel_alert;
    logic [15:0] event_count;
    logic [2:0]  mode_state;

    modport source (
        output valid, output out_disable, output dut_active, output led_on,
        output oc_clear, output sel_alert, output event_count, output mode_state,
        input ready
    );
    modport sink (
        input valid, input out_disable, input dut_active, input led_on,
        input oc_clear, input sel_alert, input event_count, input mode_state,
        output ready
    );
endinterface

FILE: src/lpc_core.sv
module lpc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_sel_event,
    input  logic            i_clear_count,
    input  logic [1:0]      i_mode,
    input  logic [15:0]     i_hold_ticks,
    output lpc_pkg::t_result o_result
);
    import lpc_pkg::*;

    logic [2:0]  r_state,   n_state;
    logic [15:0] r_tick;
    logic [15:0] r_stamp,   n_stamp;
    logic [15:0] r_events,  n_events;
    logic        r_pending, n_pending;
    logic        r_hexp,    n_hexp;
    logic        r_running, n_running;
    logic        r_led,     n_led;

    logic        ev_acc;
    logic [15:0] cnt_clr;
    logic        pend_ev, hexp_ev, run_ev, led_ev;
    logic [15:0] elapsed;
    logic        expire;

    always_comb begin
        ev_acc  = i_sel_event && (i_mode == MODE_AUTO);
        cnt_clr = i_clear_count ? 16'd0 : r_events;
        n_events = ev_acc ? cnt_clr + 16'd1 : cnt_clr;
        n_stamp  = ev_acc ? r_tick : r_stamp;
        pend_ev  = r_pending | ev_acc;
        led_ev   = r_led | ev_acc;
        run_ev   = r_running | ev_acc;

        // wrapping 16-bit elapsed time since the stamp
        elapsed   = r_tick - n_stamp;
        expire    = run_ev && (elapsed >= i_hold_ticks);
        n_running = run_ev & ~expire;
        n_led     = led_ev & ~expire;
        hexp_ev   = r_hexp | expire;

        n_pending = pend_ev;
        n_hexp    = hexp_ev;
        n_state   = r_state;
        if (i_mode == MODE_ON) begin
            n_state = ST_MAN_ON;
        end
        if (i_mode == MODE_OFF) begin
            n_state = ST_MAN_OFF;
        end
        case (r_state)
            ST_READY: begin
                if (pend_ev) begin
                    n_pending = 1'b0;
                    n_state   = ST_HOLD;
                end
            end
            ST_HOLD: begin
                n_state = ST_HOLD_CLR;
            end
            ST_HOLD_CLR: begin
                if (hexp_ev) begin
                    n_hexp  = 1'b0;
                    n_state = ST_READY;
                end
            end
            default: begin
                if (i_mode == MODE_AUTO) begin
                    n_state = ST_READY;
                end
            end
        endcase

        o_result.out_disable = (n_state == ST_MAN_OFF);
        o_result.dut_active  = (n_state == ST_MAN_OFF) || (n_state == ST_READY);
        o_result.led_on      = n_led;
        o_result.oc_clear    = (n_state == ST_HOLD);
        o_result.sel_alert   = ev_acc;
        o_result.event_count = n_events;
        o_result.mode_state  = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_tick    <= 16'd0;
            r_stamp   <= 16'd0;
            r_events  <= 16'd0;
            r_pending <= 1'b0;
            r_hexp    <= 1'b0;
            r_running <= 1'b0;
            r_led     <= 1'b0;
        end else if (i_accept) begin
            r_state   <= n_state;
            r_tick    <= r_tick + 16'd1;
            r_stamp   <= n_stamp;
            r_events  <= n_events;
            r_pending <= n_pending;
            r_hexp    <= n_hexp;
            r_running <= n_running;
            r_led     <= n_led;
        end
    end

endmodule

FILE: src/lpc_out_stage.sv
module lpc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lpc_pkg::t_result i_result,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_valid,
    output lpc_pkg::t_result o_result
);
    import lpc_pkg::*;

    logic    r_valid;
    t_result r_data;

    // a new result may enter when the stage is empty or being drained
    assign o_in_ready = ~r_valid | i_out_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

endmodule

FILE: src/latchup_protection_controller_top.sv
// the result appears on the output channel in the cycle after the input transfer
// throughput: one tick item per cycle while the sink is ready, set by the single result register
// the next item is taken while a result waits if the sink takes it in that cycle
// reset (synchronous, active low): mode machine to init, counters, stamp and flags
// cleared, mode register to forced off, hold time to 1000, output channel empty
module latchup_protection_controller_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    lpc_in_if.sink        i_in,
    lpc_out_if.source     o_out
);
    import lpc_pkg::*;

    // configuration registers
    logic [1:0]  r_mode;
    logic [15:0] r_hold_ticks;

    logic    in_accept;
    logic    stage_ready;
    t_result step_result;
    t_result out_result;

    // hold time is kept already scaled to ticks, so the step only compares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_RESET;
            r_hold_ticks <= hold_ticks(HOLD_TIME_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:      r_mode       <= i_cfg_data[1:0];
                REG_HOLD_TIME: r_hold_ticks <= hold_ticks(i_cfg_data);
                default:       r_mode       <= r_mode;
            endcase
        end
    end

    // a tick transfer is taken whenever the result register can take its result
    assign i_in.ready = stage_ready;
    assign in_accept  = i_in.valid & stage_ready;

    // the whole tick step: count clear, event capture, timer expiry, mode machine
    lpc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_sel_event   (i_in.sel_event),
        .i_clear_count (i_in.clear_count),
        .i_mode        (r_mode),
        .i_hold_ticks  (r_hold_ticks),
        .o_result      (step_result)
    );

    // result register between the step logic and the output channel
    lpc_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_accept),
        .i_result    (step_result),
        .i_out_ready (o_out.ready),
        .o_in_ready  (stage_ready),
        .o_valid     (o_out.valid),
        .o_result    (out_result)
    );

    assign o_out.out_disable = out_result.out_disable;
    assign o_out.dut_active  = out_result.dut_active;
    assign o_out.led_on      = out_result.led_on;
    assign o_out.oc_clear    = out_result.oc_clear;
    assign o_out.sel_alert   = out_result.sel_alert;
    assign o_out.event_count = out_result.event_count;
    assign o_out.mode_state  = out_result.mode_state;

endmodule
